### design/apsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

   localparam int unsigned DIST_W = 16;
   localparam logic [DIST_W-1:0] INF_DIST = '1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Saturating add: infinity absorbs, and a sum at or above infinity clamps.
   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == INF_DIST || b == INF_DIST || s >= {1'b0, INF_DIST}) begin
         return INF_DIST;
      end
      return s[DIST_W-1:0];
   endfunction

endpackage
`default_nettype wire

### design/apsp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module apsp_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/apsp_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_cell
// One column cell: holds the current row entry of its column and the pivot
// row entry of its column, which shifts in from the left neighbour.
// ----------------------------------------------------------------------------
module apsp_cell (
   input  wire logic                         clock,
   input  wire logic                         shift,
   input  wire logic                         load,
   input  wire logic [apsp_pkg::DIST_W-1:0]  load_data,
   input  wire logic                         relax,
   input  wire logic [apsp_pkg::DIST_W-1:0]  via,
   input  wire logic [apsp_pkg::DIST_W-1:0]  pivot_in,
   output      logic [apsp_pkg::DIST_W-1:0]  pivot_out,
   output      logic [apsp_pkg::DIST_W-1:0]  entry
);

   logic [apsp_pkg::DIST_W-1:0] entry_ff, entry_in;
   logic [apsp_pkg::DIST_W-1:0] pivot_ff;
   logic [apsp_pkg::DIST_W-1:0] cand;

   // A load takes priority; otherwise, on relax, the entry takes the path through the pivot vertex when it is shorter.
   always_comb begin
      cand     = apsp_pkg::sat_add(via, pivot_ff);
      entry_in = entry_ff;
      if (load) begin
         entry_in = load_data;
      end else if (relax && cand < entry_ff) begin
         entry_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (shift) begin
         pivot_ff <= pivot_in;
      end
   end

   assign pivot_out = pivot_ff;
   assign entry     = entry_ff;

endmodule
`default_nettype wire

### design/all_pairs_shortest_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall distance matrix engine with write, run and read commands.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and its single
// response appears on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall it. Write and read transactions hold busy
// high only through ST_RESP (the RAM read is issued in the accepting cycle)
// and the response follows in the cycle after that, in which a new
// transaction may already be taken. A run transaction relaxes the matrix in
// place with a chain of MAX_VERTICES column cells: for each intermediate k
// the block first streams row k out of the RAM into the chain, highest
// column first, so that after n shifts column j sits in cell j, where n is
// the active vertex count. Then for each row i it streams row i into the
// cells, waits in ST_SETTLE for the last read to land, relaxes all columns
// at once in ST_RELAX and writes the row back in ST_WRBACK. After the last
// row of the last k, busy stays high through ST_RESP; the response follows
// in the next cycle. The run time is set by the RAM, which moves one entry
// per cycle. The distance store has no reset: entries never written read as
// whatever the RAM holds.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path #(
   parameter int unsigned MAX_VERTICES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire logic [1:0]   req_op,
   input  wire logic [3:0]   req_row,
   input  wire logic [3:0]   req_col,
   input  wire logic [15:0]  req_weight,
   output      logic         rsp_valid,
   output      logic [1:0]   rsp_kind,
   output      logic [15:0]  rsp_distance,
   output      logic         rsp_unreachable,
   input  wire logic         csr_wr_en,
   input  wire logic [4:0]   csr_wr_data
);

   localparam int unsigned IW    = $clog2(MAX_VERTICES);
   localparam int unsigned AW    = 2 * IW;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
   localparam int unsigned DW    = apsp_pkg::DIST_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RESP, ST_PIVOT, ST_ROW, ST_SETTLE, ST_RELAX, ST_WRBACK
   } state_type;

   state_type        state_ff;
   logic [4:0]       vcount_ff;
   logic [CW-1:0]    n_eff;
   logic [1:0]       op_ff;
   logic             inside_ff;
   logic [IW-1:0]    k_ff, i_ff, j_ff;
   logic             pivot_fill_ff; // RAM read of the previous cycle is a pivot entry
   logic             row_fill_ff;   // RAM read of the previous cycle is a row entry
   logic [IW-1:0]    fill_j_ff;     // column that row entry belongs to
   logic [DW-1:0]    via_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [DW-1:0]    rsp_dist_ff;
   logic             rsp_unr_ff;

   logic             ram_we;
   logic [AW-1:0]    ram_wa, ram_ra;
   logic [DW-1:0]    ram_wd, ram_rd;

   logic             relax;
   logic [MAX_VERTICES-1:0] cell_load;
   logic [DW-1:0]    pivot_chain [MAX_VERTICES+1];
   logic [DW-1:0]    entries [MAX_VERTICES];

   logic             req_inside;
   logic [IW-1:0]    last_idx;

   // Clamp the vertex count to 1..MAX_VERTICES.
   always_comb begin
      if (vcount_ff == 5'd0) begin
         n_eff = CW'(1);
      end else if (32'(vcount_ff) > MAX_VERTICES) begin
         n_eff = CW'(MAX_VERTICES);
      end else begin
         n_eff = CW'(vcount_ff);
      end
      last_idx = IW'(n_eff - CW'(1));
   end

   assign req_inside = (32'(req_row) < MAX_VERTICES) && (32'(req_col) < MAX_VERTICES);

   apsp_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // The pivot row enters at the left of the chain and shifts right one cell
   // a cycle while pivot reads land; row entries load straight into their column's cell.
   assign pivot_chain[0] = ram_rd;
   assign relax          = state_ff == ST_RELAX;

   genvar g;
   generate
      for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
         assign cell_load[g] = row_fill_ff && fill_j_ff == IW'(g);
         apsp_cell u_cell (
            .clock     (clock),
            .shift     (pivot_fill_ff),
            .load      (cell_load[g]),
            .load_data (ram_rd),
            .relax     (relax),
            .via       (via_ff),
            .pivot_in  (pivot_chain[g]),
            .pivot_out (pivot_chain[g+1]),
            .entry     (entries[g])
         );
      end
   endgenerate

   // RAM addressing. A read transaction issues its read in the accepting cycle.
   always_comb begin
      ram_we = 1'b0;
      ram_wa = {IW'(req_row), IW'(req_col)};
      ram_wd = req_weight;
      ram_ra = {IW'(req_row), IW'(req_col)};
      unique case (state_ff)
         ST_IDLE: begin
            ram_we = start && req_op == apsp_pkg::OP_WRITE && req_inside;
         end
         ST_PIVOT: ram_ra = {k_ff, j_ff};
         ST_ROW:   ram_ra = {i_ff, j_ff};
         ST_WRBACK: begin
            ram_we = 1'b1;
            ram_wa = {i_ff, j_ff};
            ram_wd = entries[j_ff];
         end
         default: ;
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= 5'd16;
         rsp_valid_ff  <= 1'b0;
         pivot_fill_ff <= 1'b0;
         row_fill_ff   <= 1'b0;
      end else begin
         rsp_valid_ff  <= state_ff == ST_RESP;
         pivot_fill_ff <= state_ff == ST_PIVOT;
         row_fill_ff   <= state_ff == ST_ROW;
         fill_j_ff     <= j_ff;
         // The weight of row i through k arrives with column k of row i.
         if (row_fill_ff && fill_j_ff == k_ff) begin
            via_ff <= ram_rd;
         end
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff     <= req_op;
                  inside_ff <= req_inside;
                  k_ff      <= '0;
                  i_ff      <= '0;
                  j_ff      <= last_idx;
                  state_ff  <= (req_op == apsp_pkg::OP_RUN) ? ST_PIVOT : ST_RESP;
               end
            end
            ST_RESP: begin
               rsp_kind_ff <= op_ff;
               rsp_dist_ff <= (op_ff == apsp_pkg::OP_READ)
                              ? (inside_ff ? ram_rd : apsp_pkg::INF_DIST) : '0;
               rsp_unr_ff  <= op_ff == apsp_pkg::OP_READ
                              && (!inside_ff || ram_rd == apsp_pkg::INF_DIST);
               state_ff    <= ST_IDLE;
            end
            ST_PIVOT: begin
               // Row k is read from the highest active column down.
               if (j_ff == '0) begin
                  j_ff     <= last_idx;
                  state_ff <= ST_ROW;
               end else begin
                  j_ff <= j_ff - IW'(1);
               end
            end
            ST_ROW: begin
               if (j_ff == '0) begin
                  state_ff <= ST_SETTLE;
               end else begin
                  j_ff <= j_ff - IW'(1);
               end
            end
            // The last entry of the row lands in its cell here.
            ST_SETTLE: state_ff <= ST_RELAX;
            ST_RELAX:  state_ff <= ST_WRBACK;
            ST_WRBACK: begin
               if (j_ff == last_idx) begin
                  j_ff <= last_idx;
                  if (i_ff == last_idx) begin
                     i_ff <= '0;
                     if (k_ff == last_idx) begin
                        state_ff <= ST_RESP;
                     end else begin
                        k_ff     <= k_ff + IW'(1);
                        state_ff <= ST_PIVOT;
                     end
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= ST_ROW;
                  end
               end else begin
                  j_ff <= j_ff + IW'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_unreachable = rsp_unr_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("two responses back to back");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transaction not taken");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unreachable |-> rsp_distance == apsp_pkg::INF_DIST)
      else $error("unreachable flag without infinite distance");
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE || state_ff == ST_WRBACK))
      else $error("RAM written outside a write or write-back");

endmodule
`default_nettype wire

### test/apsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_checker
// Predicts and checks every response of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
module apsp_checker #(
   parameter int unsigned MAX_VERTICES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [3:0]  req_row,
   input  wire logic [3:0]  req_col,
   input  wire logic [15:0] req_weight,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_kind,
   input  wire logic [15:0] rsp_distance,
   input  wire logic        rsp_unreachable,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   output int               fail_count,
   output int               pending
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] distance;
      logic        unreachable;
   } apsp_rsp_type;

   logic [15:0]  dist_matrix [MAX_VERTICES*MAX_VERTICES];
   logic [4:0]   vertex_cfg;
   apsp_rsp_type awaited_rsp [$];

   function automatic logic [15:0] clamp_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == apsp_pkg::INF_DIST || b == apsp_pkg::INF_DIST || s >= 17'd65535) begin
         return apsp_pkg::INF_DIST;
      end
      return s[15:0];
   endfunction

   function automatic int active_vertices();
      if (vertex_cfg == 0) begin
         return 1;
      end
      if (vertex_cfg > MAX_VERTICES) begin
         return MAX_VERTICES;
      end
      return vertex_cfg;
   endfunction

   // In-place relaxation; the path weight through k is taken once per row.
   task automatic relax_matrix();
      int n;
      logic [15:0] via;
      logic [15:0] cand;
      n = active_vertices();
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            via = dist_matrix[i*MAX_VERTICES + k];
            for (int j = 0; j < n; j++) begin
               cand = clamp_add(via, dist_matrix[k*MAX_VERTICES + j]);
               if (cand < dist_matrix[i*MAX_VERTICES + j]) begin
                  dist_matrix[i*MAX_VERTICES + j] = cand;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      apsp_rsp_type exp_rsp;
      logic         in_store;
      if (reset) begin
         vertex_cfg = 5'd16;
         awaited_rsp.delete();
      end else begin
         // Responses are compared before this edge's transaction is predicted.
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected response kind %0d", $realtime, rsp_kind);
               end
            end else begin
               exp_rsp = awaited_rsp.pop_front();
               if (rsp_kind !== exp_rsp.kind || rsp_distance !== exp_rsp.distance ||
                   rsp_unreachable !== exp_rsp.unreachable) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch kind %0d/%0d distance %0d/%0d unreachable %0d/%0d",
                              $realtime, exp_rsp.kind, rsp_kind, exp_rsp.distance,
                              rsp_distance, exp_rsp.unreachable, rsp_unreachable);
                  end
               end
            end
         end
         if (csr_wr_en) begin
            vertex_cfg = csr_wr_data;
         end
         if (start && !busy) begin
            in_store = (32'(req_row) < MAX_VERTICES) && (32'(req_col) < MAX_VERTICES);
            exp_rsp  = '{kind: req_op, distance: 16'd0, unreachable: 1'b0};
            case (apsp_pkg::op_type'(req_op))
               apsp_pkg::OP_WRITE: begin
                  if (in_store) begin
                     dist_matrix[req_row*MAX_VERTICES + req_col] = req_weight;
                  end
               end
               apsp_pkg::OP_RUN: begin
                  relax_matrix();
               end
               apsp_pkg::OP_READ: begin
                  exp_rsp.distance    = in_store ? dist_matrix[req_row*MAX_VERTICES + req_col]
                                                 : apsp_pkg::INF_DIST;
                  exp_rsp.unreachable = (exp_rsp.distance == apsp_pkg::INF_DIST);
               end
               default: begin
               end
            endcase
            awaited_rsp.insert(awaited_rsp.size(), exp_rsp);
         end
      end
      pending <= awaited_rsp.size();
   end

endmodule

### test/all_pairs_shortest_path_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_tb
// Drives write, run and read transactions into the shortest path block.
// ----------------------------------------------------------------------------
// The whole matrix is filled first so that no entry is ever read unwritten.
// A short directed section covers the weight extremes, the clamp to infinity,
// the undefined operation and the smallest vertex count; then a series of
// phases, each with its own vertex count, sends random graph edits, reads
// and occasional relaxation runs. The checker beside the block predicts and
// compares every response.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_tb;

   localparam int unsigned MAX_VERTICES = 16;
   localparam int unsigned CYCLE_LIMIT  = 4000000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [3:0]  req_row;
   logic [3:0]  req_col;
   logic [15:0] req_weight;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_distance;
   logic        rsp_unreachable;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          burst_left;
   int          runs_sent;
   int          reads_sent;
   int          items_sent;
   int          active_n;

   // The clock runs with a 20 ns period, high and low for 10 ns each.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   all_pairs_shortest_path #(.MAX_VERTICES(MAX_VERTICES)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_row(req_row), .req_col(req_col), .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_distance(rsp_distance),
      .rsp_unreachable(rsp_unreachable), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   apsp_checker #(.MAX_VERTICES(MAX_VERTICES)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_row(req_row), .req_col(req_col), .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_distance(rsp_distance),
      .rsp_unreachable(rsp_unreachable), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // A watchdog ends a hung run; a slow but correct run stays far below it.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL all_pairs_shortest_path");
         $finish;
      end
   end

   // Sends one transaction and returns at the edge that accepts it. Start is
   // only lowered when a gap follows, so a burst keeps it high throughout.
   task automatic send_item(input apsp_pkg::op_type op, input logic [3:0] row,
                            input logic [3:0] col, input logic [15:0] weight,
                            input bit allow_gap);
      int gap;
      if (allow_gap && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         // Every so often a long stretch without gaps follows.
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      start      <= 1'b1;
      req_op     <= op;
      req_row    <= row;
      req_col    <= col;
      req_weight <= weight;
      do @(posedge clock); while (busy);
      items_sent++;
      if (op == apsp_pkg::OP_RUN) begin
         runs_sent++;
      end
      if (op == apsp_pkg::OP_READ) begin
         reads_sent++;
      end
   endtask

   // Waits until every response is in and the block has had time to settle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic set_vertex_count(input logic [4:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0) begin
         active_n = 1;
      end else if (value > MAX_VERTICES) begin
         active_n = MAX_VERTICES;
      end else begin
         active_n = value;
      end
   endtask

   // Edge weights are mostly small so that paths compose, with some absent
   // edges and some heavy ones that push sums into the clamp.
   function automatic logic [15:0] pick_weight();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         return 16'($urandom_range(0, 40));
      end else if (sel < 75) begin
         return apsp_pkg::INF_DIST;
      end else if (sel < 88) begin
         return 16'($urandom_range(30000, 65534));
      end
      return 16'($urandom());
   endfunction

   // Indices mostly fall inside the active square, sometimes anywhere.
   function automatic logic [3:0] pick_index();
      if ($urandom_range(0, 4) == 0) begin
         return 4'($urandom_range(0, MAX_VERTICES - 1));
      end
      return 4'($urandom_range(0, active_n - 1));
   endfunction

   task automatic random_phase(input logic [4:0] count_value, input int item_total);
      int sel;
      int run_weight;
      set_vertex_count(count_value);
      // Big matrices make runs slow, so they are kept rarer there.
      run_weight = (active_n >= 12) ? 1 : 5;
      for (int t = 0; t < item_total; t++) begin
         sel = $urandom_range(0, 99);
         if (sel < run_weight) begin
            send_item(apsp_pkg::OP_RUN, 4'($urandom()), 4'($urandom()), 16'($urandom()),
                      1'b1);
         end else if (sel < 52) begin
            send_item(apsp_pkg::OP_WRITE, pick_index(), pick_index(), pick_weight(), 1'b1);
         end else if (sel < 97) begin
            send_item(apsp_pkg::OP_READ, pick_index(), pick_index(), 16'($urandom()), 1'b1);
         end else begin
            send_item(apsp_pkg::OP_NONE, 4'($urandom()), 4'($urandom()), 16'($urandom()),
                      1'b1);
         end
      end
   endtask

   initial begin
      burst_left  = 0;
      runs_sent   = 0;
      reads_sent  = 0;
      items_sent  = 0;
      active_n    = MAX_VERTICES;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = apsp_pkg::OP_NONE;
      req_row     = '0;
      req_col     = '0;
      req_weight  = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole store, diagonal at zero, so no entry is ever undefined.
      set_vertex_count(5'd16);
      for (int r = 0; r < MAX_VERTICES; r++) begin
         for (int c = 0; c < MAX_VERTICES; c++) begin
            send_item(apsp_pkg::OP_WRITE, 4'(r), 4'(c), (r == c) ? 16'd0 : pick_weight(),
                      1'b0);
         end
      end

      // Directed: weight extremes, a sum that clamps to infinity, a run over
      // the full matrix, the undefined operation and a single-vertex run.
      send_item(apsp_pkg::OP_WRITE, 4'd0, 4'd1, 16'd65534, 1'b0);
      send_item(apsp_pkg::OP_WRITE, 4'd1, 4'd2, 16'd65534, 1'b0);
      send_item(apsp_pkg::OP_WRITE, 4'd0, 4'd2, apsp_pkg::INF_DIST, 1'b0);
      send_item(apsp_pkg::OP_WRITE, 4'd15, 4'd15, apsp_pkg::INF_DIST, 1'b0);
      send_item(apsp_pkg::OP_WRITE, 4'd15, 4'd0, 16'd0, 1'b0);
      send_item(apsp_pkg::OP_READ, 4'd15, 4'd15, 16'hFFFF, 1'b0);
      send_item(apsp_pkg::OP_READ, 4'd0, 4'd1, 16'd0, 1'b0);
      send_item(apsp_pkg::OP_NONE, 4'd15, 4'd15, 16'hFFFF, 1'b0);
      send_item(apsp_pkg::OP_RUN, 4'd0, 4'd0, 16'd0, 1'b0);
      send_item(apsp_pkg::OP_READ, 4'd0, 4'd2, 16'd0, 1'b0);
      send_item(apsp_pkg::OP_READ, 4'd15, 4'd15, 16'd0, 1'b0);
      set_vertex_count(5'd1);
      send_item(apsp_pkg::OP_WRITE, 4'd0, 4'd0, 16'd7, 1'b0);
      send_item(apsp_pkg::OP_RUN, 4'd0, 4'd0, 16'd0, 1'b0);
      send_item(apsp_pkg::OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
      send_item(apsp_pkg::OP_READ, 4'd3, 4'd9, 16'd0, 1'b0);

      // Random phases; out-of-range counts 0 and 31 are included.
      random_phase(5'd4, 220);
      random_phase(5'd0, 130);
      random_phase(5'd16, 170);
      random_phase(5'd7, 220);
      random_phase(5'd31, 120);
      random_phase(5'd2, 170);
      random_phase(5'($urandom_range(3, 10)), 260);
      random_phase(5'd1, 100);
      random_phase(5'($urandom_range(5, 16)), 140);

      drain();
      $display("Covered %0d transactions: %0d relaxation runs and %0d reads", items_sent,
               runs_sent, reads_sent);
      $display("Vertex counts from the smallest to the largest, with out-of-range values.");
      if (fail_count == 0) begin
         $display("PASS all_pairs_shortest_path");
      end else begin
         $display("FAIL all_pairs_shortest_path");
      end
      $finish;
   end

endmodule
